@@ rtl/core/dios_pkg.sv @@
// ----------------------------------------------------------------------------
// dios_pkg
// Shared sizes, codes and types of the deadline I/O request scheduler.
// ----------------------------------------------------------------------------
package dios_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_CLASSES = 3;
   localparam int NUM_QUEUES  = 2 * NUM_CLASSES;

   localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CLS_CNT_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int QID_W     = CLS_CNT_W + 1;

   localparam int SECTOR_W = 48;
   localparam int BLOCKS_W = 32;
   localparam int STAMP_W  = 32;
   localparam int POS_W    = 49;
   localparam int CLASS_W  = 2;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int EXPIRY_W = 16;
   localparam int STARVE_W = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_READ_EXPIRY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_EXPIRY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STARVE_LIMIT = 2'd2;

   localparam logic [EXPIRY_W-1:0] READ_EXPIRY_RST  = 16'd500;
   localparam logic [EXPIRY_W-1:0] WRITE_EXPIRY_RST = 16'd5000;
   localparam logic [STARVE_W-1:0] STARVE_LIMIT_RST = 8'd2;
   localparam logic [STARVE_W-1:0] STARVE_MAX       = 8'd255;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD      = 2'd0,
      ACT_DISPATCH = 2'd1,
      ACT_TICK     = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_ADDED      = 3'd0,
      STS_BAD_CLASS  = 3'd1,
      STS_FULL       = 3'd2,
      STS_DISPATCHED = 3'd3,
      STS_NONE       = 3'd4,
      STS_TICK       = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_TAKE,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [BLOCKS_W-1:0] blocks;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic [IDX_W-1:0] pos;
   } qctl_type;

endpackage

@@ rtl/core/dios_if.sv @@
// ----------------------------------------------------------------------------
// dios_req_if / dios_rsp_if
// Valid/ready channels carrying request words and response words.
// ----------------------------------------------------------------------------
interface dios_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [47:0] req_sector;
   logic [31:0] req_blocks;
   logic        req_write;
   logic [1:0]  req_class;

   modport source (output valid, action, req_sector, req_blocks, req_write, req_class,
                   input ready);
   modport sink   (input valid, action, req_sector, req_blocks, req_write, req_class,
                   output ready);
endinterface

interface dios_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [47:0] out_sector;
   logic [31:0] out_blocks;
   logic        out_write;
   logic [1:0]  out_class;
   logic        by_deadline;

   modport source (output valid, status, out_sector, out_blocks, out_write, out_class,
                   by_deadline, input ready);
   modport sink   (input valid, status, out_sector, out_blocks, out_write, out_class,
                   by_deadline, output ready);
endinterface

@@ rtl/core/deadline_io_request_scheduler.sv @@
// ----------------------------------------------------------------------------
// deadline_io_request_scheduler
// Six in-order request queues (three priorities by read/write) with deadline
// and nearest-position dispatch.
// ----------------------------------------------------------------------------
// One word is taken at a time. An add, a tick or an unused action answers
// without a search, and so does a dispatch that finds an overdue head.
// Otherwise the distance scan reads one entry per cycle from the queue of
// the class being searched, then goes on to the next class if it found none.
// The scan stops at the first class with an entry, so the longest case is
// two empty classes ahead of a full one of sixteen entries. The next word is
// accepted as soon as the answer moves to the output register, even while it
// waits there to be taken.
module deadline_io_request_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   dios_req_if.sink                            req_chan,
   dios_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [dios_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dios_pkg::CSR_DATA_W-1:0]     csr_data
);
   import dios_pkg::*;

   state_type state_ff, state_in;

   logic [ACTION_W-1:0] act_ff;
   logic [SECTOR_W-1:0] isec_ff;
   logic [BLOCKS_W-1:0] iblk_ff;
   logic                iwr_ff;
   logic [CLASS_W-1:0]  icls_ff;

   logic [EXPIRY_W-1:0] rd_exp_ff, wr_exp_ff;
   logic [STARVE_W-1:0] starve_lim_ff;
   logic [STARVE_W-1:0] starve_ff, starve_in;
   logic                last_wr_ff, last_wr_in;
   logic [STAMP_W-1:0]  now_ff, now_in;
   logic [POS_W-1:0]    head_pos_ff [NUM_QUEUES];
   logic [POS_W-1:0]    head_pos_in [NUM_QUEUES];

   logic [CLS_CNT_W-1:0] cls_ff, cls_in;
   logic                 dir_ff, dir_in;
   logic [FILL_W-1:0]    idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic [POS_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]     bpos_ff, bpos_in;
   logic [QID_W-1:0]     q_ff, q_in;
   logic                 dl_ff, dl_in;

   logic [STATUS_W-1:0] res_sts_ff, res_sts_in;
   logic [SECTOR_W-1:0] res_sec_ff, res_sec_in;
   logic [BLOCKS_W-1:0] res_blk_ff, res_blk_in;
   logic                res_wr_ff, res_wr_in;
   logic [CLASS_W-1:0]  res_cls_ff, res_cls_in;
   logic                res_dl_ff, res_dl_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_sts_ff;
   logic [SECTOR_W-1:0] rsp_sec_ff;
   logic [BLOCKS_W-1:0] rsp_blk_ff;
   logic                rsp_wr_ff;
   logic [CLASS_W-1:0]  rsp_cls_ff;
   logic                rsp_dl_ff;

   qctl_type          qctl       [NUM_QUEUES];
   entry_type         rd_entry   [NUM_QUEUES];
   logic [STAMP_W-1:0] head_stamp [NUM_QUEUES];
   logic [FILL_W-1:0] fill       [NUM_QUEUES];
   entry_type         push_entry;
   logic [IDX_W-1:0]  rd_idx;

   logic [NUM_QUEUES-1:0] expired;
   logic                  any_expired;
   logic [QID_W-1:0]      dl_q;
   logic                  force_wr;
   logic [QID_W-1:0]      q_sel, q_add, q_rd;
   logic [FILL_W-1:0]     fill_cur;
   entry_type             cur_entry;
   logic [POS_W-1:0]      cur_dist, cur_sec, cur_head;
   logic                  scan_more;
   logic                  bad_class, add_full;
   logic                  emit_go;

   for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
      logic [STAMP_W-1:0]  age;
      logic [EXPIRY_W-1:0] lim;
      assign age        = now_ff - head_stamp[q];
      assign lim        = (q % 2 == 1) ? wr_exp_ff : rd_exp_ff;
      assign expired[q] = (fill[q] != '0) && (age >= STAMP_W'(lim));
      dios_queue u_queue (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (qctl[q]),
         .push_entry (push_entry),
         .rd_idx     (rd_idx),
         .rd_entry   (rd_entry[q]),
         .head_stamp (head_stamp[q]),
         .fill       (fill[q])
      );
   end

   always_comb begin
      dl_q = '0;
      for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
         if (expired[q]) begin
            dl_q = QID_W'(q);
         end
      end
   end

   assign any_expired = |expired;
   assign force_wr    = !last_wr_ff && (starve_ff >= starve_lim_ff);
   assign q_sel       = {cls_ff, dir_ff};
   assign q_add       = {CLS_CNT_W'(icls_ff), iwr_ff};
   assign q_rd        = (state_ff == S_SEARCH) ? q_sel : q_ff;
   assign rd_idx      = (state_ff == S_SEARCH) ? idx_ff[IDX_W-1:0] : bpos_ff;
   assign cur_entry   = rd_entry[q_rd];
   assign fill_cur    = fill[q_sel];
   assign cur_sec     = {1'b0, cur_entry.sector};
   assign cur_head    = head_pos_ff[q_sel];
   assign cur_dist    = (cur_sec >= cur_head) ? cur_sec - cur_head : cur_head - cur_sec;
   assign scan_more   = idx_ff < fill_cur;
   assign bad_class   = 32'(icls_ff) >= NUM_CLASSES;
   assign add_full    = fill[q_add] >= FILL_W'(QUEUE_DEPTH);
   assign emit_go     = !rsp_valid_ff || rsp_chan.ready;
   assign push_entry  = '{sector: isec_ff, blocks: iblk_ff, stamp: now_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (act_ff == ACT_DISPATCH) begin
               state_in = any_expired ? S_TAKE : S_SEARCH;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SEARCH: begin
            if (!scan_more) begin
               if (found_ff) begin
                  state_in = S_TAKE;
               end else if (32'(cls_ff) == NUM_CLASSES - 1) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_TAKE: state_in = S_EMIT;
         S_EMIT: begin
            if (emit_go) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      starve_in   = starve_ff;
      last_wr_in  = last_wr_ff;
      now_in      = now_ff;
      head_pos_in = head_pos_ff;
      cls_in      = cls_ff;
      dir_in      = dir_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      bpos_in     = bpos_ff;
      q_in        = q_ff;
      dl_in       = dl_ff;
      res_sts_in  = res_sts_ff;
      res_sec_in  = res_sec_ff;
      res_blk_in  = res_blk_ff;
      res_wr_in   = res_wr_ff;
      res_cls_in  = res_cls_ff;
      res_dl_in   = res_dl_ff;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         qctl[q] = '0;
      end
      unique case (state_ff)
         S_DECODE: begin
            res_sec_in = '0;
            res_blk_in = '0;
            res_wr_in  = 1'b0;
            res_cls_in = '0;
            res_dl_in  = 1'b0;
            case (act_ff)
               ACT_ADD: begin
                  if (bad_class) begin
                     res_sts_in = STS_BAD_CLASS;
                  end else if (add_full) begin
                     res_sts_in = STS_FULL;
                  end else begin
                     qctl[q_add].push = 1'b1;
                     res_sts_in       = STS_ADDED;
                  end
               end
               ACT_DISPATCH: begin
                  if (any_expired) begin
                     q_in    = dl_q;
                     bpos_in = '0;
                     dl_in   = 1'b1;
                  end else begin
                     dir_in    = last_wr_ff || force_wr;
                     starve_in = force_wr ? '0 : starve_ff;
                     cls_in    = '0;
                     idx_in    = '0;
                     found_in  = 1'b0;
                     dl_in     = 1'b0;
                  end
               end
               ACT_TICK: begin
                  now_in     = now_ff + STAMP_W'(1);
                  res_sts_in = STS_TICK;
               end
               default: res_sts_in = STS_NONE;
            endcase
         end
         S_SEARCH: begin
            if (scan_more) begin
               if (!found_ff || cur_dist < best_ff) begin
                  best_in  = cur_dist;
                  bpos_in  = idx_ff[IDX_W-1:0];
                  found_in = 1'b1;
               end
               idx_in = idx_ff + FILL_W'(1);
            end else if (found_ff) begin
               q_in = q_sel;
            end else if (32'(cls_ff) == NUM_CLASSES - 1) begin
               if (!dir_ff && starve_ff != STARVE_MAX) begin
                  starve_in = starve_ff + STARVE_W'(1);
               end
               res_sts_in = STS_NONE;
            end else begin
               cls_in = cls_ff + CLS_CNT_W'(1);
               idx_in = '0;
            end
         end
         S_TAKE: begin
            qctl[q_ff].pop   = 1'b1;
            qctl[q_ff].pos   = bpos_ff;
            head_pos_in[q_ff] = {1'b0, cur_entry.sector} + POS_W'(cur_entry.blocks);
            last_wr_in       = q_ff[0];
            res_sts_in       = STS_DISPATCHED;
            res_sec_in       = cur_entry.sector;
            res_blk_in       = cur_entry.blocks;
            res_wr_in        = q_ff[0];
            res_cls_in       = CLASS_W'(q_ff[QID_W-1:1]);
            res_dl_in        = dl_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_exp_ff     <= READ_EXPIRY_RST;
         wr_exp_ff     <= WRITE_EXPIRY_RST;
         starve_lim_ff <= STARVE_LIMIT_RST;
         starve_ff     <= '0;
         last_wr_ff    <= 1'b0;
         now_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_pos_ff[q] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         starve_ff   <= starve_in;
         last_wr_ff  <= last_wr_in;
         now_ff      <= now_in;
         head_pos_ff <= head_pos_in;
         if (csr_we) begin
            case (csr_index)
               CSR_READ_EXPIRY:  rd_exp_ff     <= csr_data;
               CSR_WRITE_EXPIRY: wr_exp_ff     <= csr_data;
               CSR_STARVE_LIMIT: starve_lim_ff <= csr_data[STARVE_W-1:0];
               default: begin
               end
            endcase
         end
         if (state_ff == S_EMIT && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cls_ff     <= cls_in;
      dir_ff     <= dir_in;
      idx_ff     <= idx_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      bpos_ff    <= bpos_in;
      q_ff       <= q_in;
      dl_ff      <= dl_in;
      res_sts_ff <= res_sts_in;
      res_sec_ff <= res_sec_in;
      res_blk_ff <= res_blk_in;
      res_wr_ff  <= res_wr_in;
      res_cls_ff <= res_cls_in;
      res_dl_ff  <= res_dl_in;
      if (state_ff == S_IDLE && req_chan.valid) begin
         act_ff  <= req_chan.action;
         isec_ff <= req_chan.req_sector;
         iblk_ff <= req_chan.req_blocks;
         iwr_ff  <= req_chan.req_write;
         icls_ff <= req_chan.req_class;
      end
      if (state_ff == S_EMIT && emit_go) begin
         rsp_sts_ff <= res_sts_ff;
         rsp_sec_ff <= res_sec_ff;
         rsp_blk_ff <= res_blk_ff;
         rsp_wr_ff  <= res_wr_ff;
         rsp_cls_ff <= res_cls_ff;
         rsp_dl_ff  <= res_dl_ff;
      end
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_sts_ff;
   assign rsp_chan.out_sector  = rsp_sec_ff;
   assign rsp_chan.out_blocks  = rsp_blk_ff;
   assign rsp_chan.out_write   = rsp_wr_ff;
   assign rsp_chan.out_class   = rsp_cls_ff;
   assign rsp_chan.by_deadline = rsp_dl_ff;

endmodule

@@ rtl/core/dios_cell.sv @@
// ----------------------------------------------------------------------------
// dios_cell
// One queue slot: loads a new entry or takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module dios_cell (
   input  logic                clock,
   input  logic                load,
   input  logic                shift,
   input  dios_pkg::entry_type new_entry,
   input  dios_pkg::entry_type next_entry,
   output dios_pkg::entry_type entry
);
   import dios_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= new_entry;
      end else if (shift) begin
         entry_ff <= next_entry;
      end
   end

   assign entry = entry_ff;

endmodule

@@ rtl/core/dios_queue.sv @@
// ----------------------------------------------------------------------------
// dios_queue
// In-order queue as a chain of cells; pop at any slot closes the gap.
// ----------------------------------------------------------------------------
module dios_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  dios_pkg::qctl_type               ctrl,
   input  dios_pkg::entry_type              push_entry,
   input  logic [dios_pkg::IDX_W-1:0]       rd_idx,
   output dios_pkg::entry_type              rd_entry,
   output logic [dios_pkg::STAMP_W-1:0]     head_stamp,
   output logic [dios_pkg::FILL_W-1:0]      fill
);
   import dios_pkg::*;

   logic [FILL_W-1:0] fill_ff, fill_in;
   entry_type         cell_q [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type next_e;
      logic      load_i, shift_i;
      if (i + 1 < QUEUE_DEPTH) begin : g_mid
         assign next_e = cell_q[i+1];
      end else begin : g_end
         assign next_e = cell_q[i];
      end
      assign load_i  = ctrl.push && (fill_ff == FILL_W'(i));
      assign shift_i = ctrl.pop && (IDX_W'(i) >= ctrl.pos);
      dios_cell u_cell (
         .clock      (clock),
         .load       (load_i),
         .shift      (shift_i),
         .new_entry  (push_entry),
         .next_entry (next_e),
         .entry      (cell_q[i])
      );
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctrl.push) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (ctrl.pop) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign rd_entry   = cell_q[rd_idx];
   assign head_stamp = cell_q[0].stamp;
   assign fill       = fill_ff;

endmodule
